// ----- rtl/tdei_pkg.sv -----
package tdei_pkg;

    localparam int unsigned IdWidth = 31;
    localparam int unsigned DataWidth = 32;
    localparam int unsigned OutDataWidth = 16;

    typedef enum logic [3:0] {
        ST_IDLE           = 4'd0,
        ST_GRANTED        = 4'd1,
        ST_ENTRY_UNLOCKED = 4'd2,
        ST_ENTRY_OPENED   = 4'd3,
        ST_WEIGHED        = 4'd4,
        ST_ENTRY_CLOSED   = 4'd5,
        ST_ENTRY_SECURED  = 4'd6,
        ST_EXIT_UNLOCKED  = 4'd7,
        ST_EXIT_OPENED    = 4'd8,
        ST_EXIT_CLOSED    = 4'd9,
        ST_FINAL          = 4'd10
    } ctrl_state_t;

    typedef enum logic [2:0] {
        STS_ADVANCED   = 3'd0,
        STS_DENIED     = 3'd1,
        STS_WRONG_DOOR = 3'd2,
        STS_INVALID    = 3'd3,
        STS_LOCKED     = 3'd4,
        STS_CANCELLED  = 3'd5,
        STS_COMPLETE   = 3'd6,
        STS_SHUTDOWN   = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        EV_LEFT_SCAN    = 4'd0,
        EV_RIGHT_SCAN   = 4'd1,
        EV_WEIGHT       = 4'd2,
        EV_LEFT_OPEN    = 4'd3,
        EV_RIGHT_OPEN   = 4'd4,
        EV_LEFT_CLOSE   = 4'd5,
        EV_RIGHT_CLOSE  = 4'd6,
        EV_LEFT_UNLOCK  = 4'd7,
        EV_RIGHT_UNLOCK = 4'd8,
        EV_LEFT_LOCK    = 4'd9,
        EV_RIGHT_LOCK   = 4'd10,
        EV_EXIT         = 4'd11
    } event_t;

    localparam logic [0:0] REG_MIN_PERSON_ID = 1'b0;
    localparam logic [0:0] REG_MAX_PERSON_ID = 1'b1;

    typedef struct packed {
        logic        entry_is_right;
        logic        right_opened_out;
        logic        right_unlocked_out;
        logic        left_opened_out;
        logic        left_unlocked_out;
        status_t     status;
        ctrl_state_t ctrl_state_out;
    } result_t;

endpackage

// ----- rtl/two_door_entry_interlock_fsm.sv -----
// Channel  | Direction | Data bits (lowest first)                         | User bits
// s_       | in        | tdata[31:0] data_value (signed)                  | tuser[3:0] operation
// m_       | out       | tdata: ctrl_state_out[3:0], status[6:4],         | none
//          |           | left_unlocked[7], left_opened[8], right_unlocked[9],
//          |           | right_opened[10], entry_is_right[11], zero[15:12]|
// cfg_     | in        | cfg_wdata[30:0], cfg_addr selects the register   | none
//
// One item per clock while s_tready is high: an accepted item updates the interlock
// state, and its result is registered for m_, or in the skid register if m_ stalls.
// The result side has an output register and a skid register, so one further item
// is accepted while a result is stalled; s_tready falls only when both are full.
// Reset is synchronous and active low, and leaves the interlock idle with the
// identifier window fully open.
module two_door_entry_interlock_fsm (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [tdei_pkg::DataWidth-1:0]       s_tdata,   // data_value
    input  logic [3:0]                           s_tuser,   // operation
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tdei_pkg::OutDataWidth-1:0]    m_tdata,   // see table above
    input  logic                                 cfg_wr_en,
    input  logic [0:0]                           cfg_addr,
    input  logic [tdei_pkg::IdWidth-1:0]         cfg_wdata
);
    import tdei_pkg::*;

    logic [IdWidth-1:0] min_id_reg;
    logic [IdWidth-1:0] max_id_reg;

    ctrl_state_t state_reg, state_next;
    logic le_reg, lu_reg, lo_reg, re_reg, ru_reg, ro_reg, auth_reg, weight_ok_reg;
    logic le_next, lu_next, lo_next, re_next, ru_next, ro_next, auth_next, weight_ok_next;
    status_t sts;

    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;

    event_t op;
    logic   accept, pop, ev_right, sel_entr, sel_unl, id_ok;

    assign op       = event_t'(s_tuser);
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataWidth - $bits(result_t)){1'b0}}, out_reg};

    assign ev_right = (op == EV_RIGHT_SCAN) || (op == EV_RIGHT_OPEN) ||
                      (op == EV_RIGHT_CLOSE) || (op == EV_RIGHT_UNLOCK) ||
                      (op == EV_RIGHT_LOCK);
    assign sel_entr = ev_right ? re_reg : le_reg;
    assign sel_unl  = ev_right ? ru_reg : lu_reg;
    assign id_ok    = !s_tdata[DataWidth-1] && (s_tdata[IdWidth-1:0] >= min_id_reg) &&
                      (s_tdata[IdWidth-1:0] <= max_id_reg);

    always_comb begin
        state_next     = state_reg;
        le_next        = le_reg;
        lu_next        = lu_reg;
        lo_next        = lo_reg;
        re_next        = re_reg;
        ru_next        = ru_reg;
        ro_next        = ro_reg;
        auth_next      = auth_reg;
        weight_ok_next = weight_ok_reg;
        sts            = STS_INVALID;
        case (state_reg)
            ST_IDLE: begin
                le_next = 1'b0;
                lu_next = 1'b0;
                lo_next = 1'b0;
                re_next = 1'b0;
                ru_next = 1'b0;
                ro_next = 1'b0;
                if (op == EV_EXIT) begin
                    state_next = ST_FINAL;
                    sts        = STS_SHUTDOWN;
                end else if (op == EV_LEFT_SCAN || op == EV_RIGHT_SCAN) begin
                    auth_next = id_ok;
                    if (id_ok) begin
                        re_next    = ev_right;
                        le_next    = !ev_right;
                        state_next = ST_GRANTED;
                        sts        = STS_ADVANCED;
                    end else begin
                        sts = STS_DENIED;
                    end
                end else begin
                    auth_next = 1'b0;
                end
            end
            ST_GRANTED: begin
                if (op == EV_LEFT_UNLOCK || op == EV_RIGHT_UNLOCK) begin
                    if (sel_entr) begin
                        if (ev_right) ru_next = 1'b1; else lu_next = 1'b1;
                        state_next = ST_ENTRY_UNLOCKED;
                        sts        = STS_ADVANCED;
                    end else begin
                        sts = STS_WRONG_DOOR;
                    end
                end
            end
            ST_ENTRY_UNLOCKED: begin
                if (op == EV_LEFT_OPEN || op == EV_RIGHT_OPEN) begin
                    if (!sel_entr) begin
                        sts = STS_WRONG_DOOR;
                    end else if (!sel_unl) begin
                        sts = STS_LOCKED;
                    end else begin
                        if (ev_right) ro_next = 1'b1; else lo_next = 1'b1;
                        state_next = ST_ENTRY_OPENED;
                        sts        = STS_ADVANCED;
                    end
                end
            end
            ST_ENTRY_OPENED, ST_WEIGHED: begin
                if (op == EV_WEIGHT && state_reg == ST_ENTRY_OPENED) begin
                    weight_ok_next = !s_tdata[DataWidth-1] && (s_tdata != '0);
                    state_next     = ST_WEIGHED;
                    sts            = STS_ADVANCED;
                end else if (op == EV_LEFT_CLOSE || op == EV_RIGHT_CLOSE) begin
                    if (sel_entr) begin
                        if (ev_right) ro_next = 1'b0; else lo_next = 1'b0;
                        state_next = ST_ENTRY_CLOSED;
                        sts        = STS_ADVANCED;
                    end else begin
                        sts = STS_WRONG_DOOR;
                    end
                end
            end
            ST_ENTRY_CLOSED: begin
                if (op == EV_LEFT_LOCK || op == EV_RIGHT_LOCK) begin
                    if (sel_entr) begin
                        if (ev_right) ru_next = 1'b0; else lu_next = 1'b0;
                        state_next = ST_ENTRY_SECURED;
                        sts        = STS_ADVANCED;
                    end else begin
                        sts = STS_WRONG_DOOR;
                    end
                end
            end
            ST_ENTRY_SECURED: begin
                if (!weight_ok_reg) begin
                    le_next        = 1'b0;
                    lu_next        = 1'b0;
                    lo_next        = 1'b0;
                    re_next        = 1'b0;
                    ru_next        = 1'b0;
                    ro_next        = 1'b0;
                    auth_next      = 1'b0;
                    weight_ok_next = 1'b0;
                    state_next     = ST_IDLE;
                    sts            = STS_CANCELLED;
                end else if (op == EV_LEFT_UNLOCK || op == EV_RIGHT_UNLOCK) begin
                    if (sel_entr) begin
                        sts = STS_WRONG_DOOR;
                    end else begin
                        if (ev_right) ru_next = 1'b1; else lu_next = 1'b1;
                        state_next = ST_EXIT_UNLOCKED;
                        sts        = STS_ADVANCED;
                    end
                end
            end
            ST_EXIT_UNLOCKED: begin
                if (op == EV_LEFT_OPEN || op == EV_RIGHT_OPEN) begin
                    if (sel_entr) begin
                        sts = STS_WRONG_DOOR;
                    end else begin
                        if (ev_right) ro_next = 1'b1; else lo_next = 1'b1;
                        state_next = ST_EXIT_OPENED;
                        sts        = STS_ADVANCED;
                    end
                end
            end
            ST_EXIT_OPENED: begin
                if (op == EV_LEFT_CLOSE || op == EV_RIGHT_CLOSE) begin
                    if (sel_entr) begin
                        sts = STS_WRONG_DOOR;
                    end else begin
                        if (ev_right) ro_next = 1'b0; else lo_next = 1'b0;
                        state_next = ST_EXIT_CLOSED;
                        sts        = STS_ADVANCED;
                    end
                end
            end
            ST_EXIT_CLOSED: begin
                if (op == EV_LEFT_LOCK || op == EV_RIGHT_LOCK) begin
                    if (sel_entr) begin
                        sts = STS_WRONG_DOOR;
                    end else begin
                        le_next        = 1'b0;
                        lu_next        = 1'b0;
                        lo_next        = 1'b0;
                        re_next        = 1'b0;
                        ru_next        = 1'b0;
                        ro_next        = 1'b0;
                        auth_next      = 1'b0;
                        weight_ok_next = 1'b0;
                        state_next     = ST_IDLE;
                        sts            = STS_COMPLETE;
                    end
                end
            end
            default: begin
                state_next = ST_FINAL;
                sts        = STS_SHUTDOWN;
            end
        endcase
    end

    always_comb begin
        res.ctrl_state_out     = state_next;
        res.status             = sts;
        res.left_unlocked_out  = lu_next;
        res.left_opened_out    = lo_next;
        res.right_unlocked_out = ru_next;
        res.right_opened_out   = ro_next;
        res.entry_is_right     = re_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_id_reg     <= '0;
            max_id_reg     <= '1;
            state_reg      <= ST_IDLE;
            le_reg         <= 1'b0;
            lu_reg         <= 1'b0;
            lo_reg         <= 1'b0;
            re_reg         <= 1'b0;
            ru_reg         <= 1'b0;
            ro_reg         <= 1'b0;
            auth_reg       <= 1'b0;
            weight_ok_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_MIN_PERSON_ID) min_id_reg <= cfg_wdata;
                if (cfg_addr == REG_MAX_PERSON_ID) max_id_reg <= cfg_wdata;
            end
            if (accept) begin
                state_reg     <= state_next;
                le_reg        <= le_next;
                lu_reg        <= lu_next;
                lo_reg        <= lo_next;
                re_reg        <= re_next;
                ru_reg        <= ru_next;
                ro_reg        <= ro_next;
                auth_reg      <= auth_next;
                weight_ok_reg <= weight_ok_next;
            end
            if (!out_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= accept;
                    if (accept) skid_reg <= res;
                end else begin
                    out_valid_reg <= accept;
                    if (accept) out_reg <= res;
                end
            end else if (accept) begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while the output register is empty");

    a_one_entrance: assert property (@(posedge aclk) disable iff (!aresetn)
        !(le_reg && re_reg))
        else $error("both doors marked as entrance");

    a_idle_doors_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(lu_reg || lo_reg || ru_reg || ro_reg || le_reg || re_reg))
        else $error("door flags set while idle");

    a_final_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL) |=> (state_reg == ST_FINAL))
        else $error("left the final state");

    a_not_both_unlocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !(lu_reg && ru_reg))
        else $error("both doors unlocked at once");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tdei_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [3:0] EV_UNDEFINED_FIRST = 4'd12;
    localparam logic [3:0] EV_UNDEFINED_LAST = 4'd15;
    localparam logic [IdWidth-1:0] ID_TOP = '1;
    localparam int unsigned PHASES = 6;
    localparam int unsigned ITEMS_PER_PHASE = 105;

    class interlock_scoreboard;
        ctrl_state_t state;
        bit left_entr, left_unl, left_opn;
        bit right_entr, right_unl, right_opn;
        bit authorised;
        logic [DataWidth-1:0] weight;
        logic [IdWidth-1:0] id_min, id_max;
        result_t awaited[$];
        int unsigned errors;

        function new();
            state = ST_IDLE;
            id_min = '0;
            id_max = ID_TOP;
            errors = 0;
            clear_all();
        endfunction

        function void clear_doors();
            left_entr = 1'b0;
            left_unl = 1'b0;
            left_opn = 1'b0;
            right_entr = 1'b0;
            right_unl = 1'b0;
            right_opn = 1'b0;
        endfunction

        function void clear_all();
            clear_doors();
            authorised = 1'b0;
            weight = '0;
        endfunction

        function void write_reg(logic [0:0] index, logic [IdWidth-1:0] value);
            if (index == REG_MIN_PERSON_ID) begin
                id_min = value;
            end else begin
                id_max = value;
            end
        endfunction

        function bit entrance(bit is_right);
            return is_right ? right_entr : left_entr;
        endfunction

        function void set_unlocked(bit is_right, bit value);
            if (is_right) begin
                right_unl = value;
            end else begin
                left_unl = value;
            end
        endfunction

        function void set_opened(bit is_right, bit value);
            if (is_right) begin
                right_opn = value;
            end else begin
                left_opn = value;
            end
        endfunction

        function result_t step_interlock(logic [3:0] op, logic [DataWidth-1:0] data);
            status_t sts;
            bit is_right;
            result_t res;
            sts = STS_INVALID;
            case (state)
                ST_IDLE: begin
                    clear_doors();
                    if (op == EV_EXIT) begin
                        state = ST_FINAL;
                        sts = STS_SHUTDOWN;
                    end else if (op == EV_LEFT_SCAN || op == EV_RIGHT_SCAN) begin
                        authorised = !data[DataWidth-1] && data >= {1'b0, id_min}
                                     && data <= {1'b0, id_max};
                        if (authorised) begin
                            if (op == EV_RIGHT_SCAN) begin
                                right_entr = 1'b1;
                            end else begin
                                left_entr = 1'b1;
                            end
                            state = ST_GRANTED;
                            sts = STS_ADVANCED;
                        end else begin
                            sts = STS_DENIED;
                        end
                    end else begin
                        authorised = 1'b0;
                    end
                end
                ST_GRANTED: begin
                    if (op == EV_LEFT_UNLOCK || op == EV_RIGHT_UNLOCK) begin
                        is_right = (op == EV_RIGHT_UNLOCK);
                        if (entrance(is_right)) begin
                            set_unlocked(is_right, 1'b1);
                            state = ST_ENTRY_UNLOCKED;
                            sts = STS_ADVANCED;
                        end else begin
                            sts = STS_WRONG_DOOR;
                        end
                    end
                end
                ST_ENTRY_UNLOCKED: begin
                    if (op == EV_LEFT_OPEN || op == EV_RIGHT_OPEN) begin
                        is_right = (op == EV_RIGHT_OPEN);
                        if (!entrance(is_right)) begin
                            sts = STS_WRONG_DOOR;
                        end else if (!(is_right ? right_unl : left_unl)) begin
                            sts = STS_LOCKED;
                        end else begin
                            set_opened(is_right, 1'b1);
                            state = ST_ENTRY_OPENED;
                            sts = STS_ADVANCED;
                        end
                    end
                end
                ST_ENTRY_OPENED, ST_WEIGHED: begin
                    if (op == EV_WEIGHT && state == ST_ENTRY_OPENED) begin
                        weight = data;
                        state = ST_WEIGHED;
                        sts = STS_ADVANCED;
                    end else if (op == EV_LEFT_CLOSE || op == EV_RIGHT_CLOSE) begin
                        is_right = (op == EV_RIGHT_CLOSE);
                        if (entrance(is_right)) begin
                            set_opened(is_right, 1'b0);
                            state = ST_ENTRY_CLOSED;
                            sts = STS_ADVANCED;
                        end else begin
                            sts = STS_WRONG_DOOR;
                        end
                    end
                end
                ST_ENTRY_CLOSED: begin
                    if (op == EV_LEFT_LOCK || op == EV_RIGHT_LOCK) begin
                        is_right = (op == EV_RIGHT_LOCK);
                        if (entrance(is_right)) begin
                            set_unlocked(is_right, 1'b0);
                            state = ST_ENTRY_SECURED;
                            sts = STS_ADVANCED;
                        end else begin
                            sts = STS_WRONG_DOOR;
                        end
                    end
                end
                ST_ENTRY_SECURED: begin
                    // A weight of zero or below aborts the passage on whatever comes next.
                    if (weight == '0 || weight[DataWidth-1]) begin
                        clear_all();
                        state = ST_IDLE;
                        sts = STS_CANCELLED;
                    end else if (op == EV_LEFT_UNLOCK || op == EV_RIGHT_UNLOCK) begin
                        is_right = (op == EV_RIGHT_UNLOCK);
                        if (entrance(is_right)) begin
                            sts = STS_WRONG_DOOR;
                        end else begin
                            set_unlocked(is_right, 1'b1);
                            state = ST_EXIT_UNLOCKED;
                            sts = STS_ADVANCED;
                        end
                    end
                end
                ST_EXIT_UNLOCKED: begin
                    if (op == EV_LEFT_OPEN || op == EV_RIGHT_OPEN) begin
                        is_right = (op == EV_RIGHT_OPEN);
                        if (entrance(is_right)) begin
                            sts = STS_WRONG_DOOR;
                        end else begin
                            set_opened(is_right, 1'b1);
                            state = ST_EXIT_OPENED;
                            sts = STS_ADVANCED;
                        end
                    end
                end
                ST_EXIT_OPENED: begin
                    if (op == EV_LEFT_CLOSE || op == EV_RIGHT_CLOSE) begin
                        is_right = (op == EV_RIGHT_CLOSE);
                        if (entrance(is_right)) begin
                            sts = STS_WRONG_DOOR;
                        end else begin
                            set_opened(is_right, 1'b0);
                            state = ST_EXIT_CLOSED;
                            sts = STS_ADVANCED;
                        end
                    end
                end
                ST_EXIT_CLOSED: begin
                    if (op == EV_LEFT_LOCK || op == EV_RIGHT_LOCK) begin
                        is_right = (op == EV_RIGHT_LOCK);
                        if (entrance(is_right)) begin
                            sts = STS_WRONG_DOOR;
                        end else begin
                            clear_all();
                            state = ST_IDLE;
                            sts = STS_COMPLETE;
                        end
                    end
                end
                default: begin
                    state = ST_FINAL;
                    sts = STS_SHUTDOWN;
                end
            endcase
            res.ctrl_state_out = state;
            res.status = sts;
            res.left_unlocked_out = left_unl;
            res.left_opened_out = left_opn;
            res.right_unlocked_out = right_unl;
            res.right_opened_out = right_opn;
            res.entry_is_right = right_entr;
            return res;
        endfunction

        function void note_event(logic [3:0] op, logic [DataWidth-1:0] data);
            awaited.push_back(step_interlock(op, data));
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OutDataWidth-1:0] word);
            result_t want;
            result_t got;
            if (awaited.size() == 0) begin
                $error("result %h arrived with no event outstanding", word);
                errors++;
                return;
            end
            want = awaited.pop_front();
            got = word[$bits(result_t)-1:0];
            compare("ctrl_state_out", 32'(want.ctrl_state_out), 32'(got.ctrl_state_out));
            compare("status", 32'(want.status), 32'(got.status));
            compare("left_unlocked_out", 32'(want.left_unlocked_out),
                    32'(got.left_unlocked_out));
            compare("left_opened_out", 32'(want.left_opened_out),
                    32'(got.left_opened_out));
            compare("right_unlocked_out", 32'(want.right_unlocked_out),
                    32'(got.right_unlocked_out));
            compare("right_opened_out", 32'(want.right_opened_out),
                    32'(got.right_opened_out));
            compare("entry_is_right", 32'(want.entry_is_right), 32'(got.entry_is_right));
            compare("tdata padding", '0, 32'(word[OutDataWidth-1:$bits(result_t)]));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DataWidth-1:0] s_tdata = '0;
    logic [3:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OutDataWidth-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [0:0] cfg_addr = REG_MIN_PERSON_ID;
    logic [IdWidth-1:0] cfg_wdata = '0;

    interlock_scoreboard sb = new();
    int unsigned src_gap = 32;
    int unsigned cycle_count = 0;

    two_door_entry_interlock_fsm uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // The receiver refuses everything for a long while early on, so that the block
    // fills up and pushes back on the sender, and later accepts every item for a while.
    initial begin
        int unsigned rx_cycle;
        rx_cycle = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (rx_cycle >= 150 && rx_cycle < 230) begin
                m_tready = 1'b0;
            end else if (rx_cycle >= 600 && rx_cycle < 1100) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(99) >= 32);
            end
        end
    end

    function automatic logic [3:0] door_op(event_t left_ev, event_t right_ev, bit right_side);
        return right_side ? right_ev : left_ev;
    endfunction

    function automatic logic [DataWidth-1:0] pick_id();
        int unsigned r;
        r = $urandom_range(99);
        if (sb.id_min > sb.id_max || r < 8) begin
            return $urandom;
        end else if (r < 16) begin
            return {1'b0, sb.id_min};
        end else if (r < 24) begin
            return {1'b0, sb.id_max};
        end else if (r < 28) begin
            return {1'b0, sb.id_min} - 32'd1;
        end else if (r < 32) begin
            return {1'b0, sb.id_max} + 32'd1;
        end
        return $urandom_range(sb.id_max, sb.id_min);
    endfunction

    function automatic logic [DataWidth-1:0] pick_weight();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 6) begin
            return '0;
        end else if (r < 12) begin
            return {1'b1, 31'($urandom)};
        end else if (r < 16) begin
            return 32'h7fff_ffff;
        end
        return $urandom_range(400, 1);
    endfunction

    // Mostly the next step of a correct passage, with random content; the rest is noise.
    task automatic next_event(input bit allow_noise, output logic [3:0] op,
                              output logic [DataWidth-1:0] data);
        bit side;
        side = sb.right_entr;
        data = $urandom;
        if ((allow_noise && $urandom_range(99) < 25) || sb.state == ST_FINAL) begin
            do begin
                op = 4'($urandom_range(EV_UNDEFINED_LAST, 0));
            end while (sb.state == ST_IDLE && op == EV_EXIT);
        end else begin
            case (sb.state)
                ST_IDLE: begin
                    side = 1'($urandom_range(1));
                    op = door_op(EV_LEFT_SCAN, EV_RIGHT_SCAN, side);
                    data = pick_id();
                end
                ST_GRANTED: op = door_op(EV_LEFT_UNLOCK, EV_RIGHT_UNLOCK, side);
                ST_ENTRY_UNLOCKED: op = door_op(EV_LEFT_OPEN, EV_RIGHT_OPEN, side);
                ST_ENTRY_OPENED: begin
                    if ($urandom_range(99) < 80) begin
                        op = EV_WEIGHT;
                        data = pick_weight();
                    end else begin
                        op = door_op(EV_LEFT_CLOSE, EV_RIGHT_CLOSE, side);
                    end
                end
                ST_WEIGHED: op = door_op(EV_LEFT_CLOSE, EV_RIGHT_CLOSE, side);
                ST_ENTRY_CLOSED: op = door_op(EV_LEFT_LOCK, EV_RIGHT_LOCK, side);
                ST_ENTRY_SECURED: op = door_op(EV_LEFT_UNLOCK, EV_RIGHT_UNLOCK, !side);
                ST_EXIT_UNLOCKED: op = door_op(EV_LEFT_OPEN, EV_RIGHT_OPEN, !side);
                ST_EXIT_OPENED: op = door_op(EV_LEFT_CLOSE, EV_RIGHT_CLOSE, !side);
                default: op = door_op(EV_LEFT_LOCK, EV_RIGHT_LOCK, !side);
            endcase
        end
    endtask

    task automatic send_event(input logic [3:0] op, input logic [DataWidth-1:0] data);
        @(negedge aclk);
        while ($urandom_range(99) < src_gap) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = data;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_event(op, data);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.awaited.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_window(input logic [IdWidth-1:0] lo, input logic [IdWidth-1:0] hi);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = REG_MIN_PERSON_ID;
        cfg_wdata = lo;
        @(negedge aclk);
        cfg_addr = REG_MAX_PERSON_ID;
        cfg_wdata = hi;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_reg(REG_MIN_PERSON_ID, lo);
        sb.write_reg(REG_MAX_PERSON_ID, hi);
    endtask

    initial begin
        logic [3:0] op;
        logic [DataWidth-1:0] data;
        logic [IdWidth-1:0] win_lo[PHASES];
        logic [IdWidth-1:0] win_hi[PHASES];
        win_lo = '{'0, '0, ID_TOP, 31'd1000, 31'd16, '0};
        win_hi = '{ID_TOP, '0, ID_TOP, 31'd5000, 31'd8, ID_TOP};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // One passage entered from the right with wrong-door and out-of-state cases
        // along the way, then a left passage closed before weighing, which cancels.
        send_event(EV_LEFT_OPEN, $urandom);
        send_event(EV_UNDEFINED_FIRST, $urandom);
        send_event(EV_LEFT_SCAN, 32'h8000_0000);
        send_event(EV_RIGHT_SCAN, 32'h7fff_ffff);
        send_event(EV_LEFT_UNLOCK, $urandom);
        send_event(EV_RIGHT_UNLOCK, $urandom);
        send_event(EV_LEFT_OPEN, $urandom);
        send_event(EV_RIGHT_OPEN, $urandom);
        send_event(EV_WEIGHT, 32'h7fff_ffff);
        send_event(EV_WEIGHT, 32'd5);
        send_event(EV_LEFT_CLOSE, $urandom);
        send_event(EV_RIGHT_CLOSE, $urandom);
        send_event(EV_RIGHT_LOCK, $urandom);
        send_event(EV_UNDEFINED_LAST, $urandom);
        send_event(EV_RIGHT_UNLOCK, $urandom);
        send_event(EV_LEFT_UNLOCK, $urandom);
        send_event(EV_EXIT, $urandom);
        send_event(EV_LEFT_OPEN, $urandom);
        send_event(EV_LEFT_CLOSE, $urandom);
        send_event(EV_RIGHT_LOCK, $urandom);
        send_event(EV_LEFT_LOCK, $urandom);
        send_event(EV_LEFT_SCAN, 32'd0);
        send_event(EV_LEFT_UNLOCK, $urandom);
        send_event(EV_LEFT_OPEN, $urandom);
        send_event(EV_LEFT_CLOSE, $urandom);
        send_event(EV_LEFT_LOCK, $urandom);
        send_event(EV_RIGHT_SCAN, 32'd7);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                write_window(win_lo[phase], win_hi[phase]);
            end
            src_gap = (phase == 2) ? 0 : 32;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                next_event(1'b1, op, data);
                send_event(op, data);
            end
        end

        // Bring the interlock back to idle, shut it down and prod the final state.
        for (int k = 0; k < 40 && sb.state != ST_IDLE; k++) begin
            next_event(1'b0, op, data);
            send_event(op, data);
        end
        send_event(EV_EXIT, $urandom);
        send_event(EV_LEFT_SCAN, 32'd1);
        send_event(EV_EXIT, $urandom);
        send_event(EV_UNDEFINED_LAST, $urandom);
        for (int k = 0; k < 4; k++) begin
            send_event(4'($urandom_range(EV_UNDEFINED_LAST, 0)), $urandom);
        end

        wait_drained();
        repeat (5) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tdei_pkg.sv
rtl/two_door_entry_interlock_fsm.sv
dv/tb_top.sv
